// File: design/roc_pkg.sv
// Shared types, constants and helpers of the open cylinder ray intersector.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package roc_pkg;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int CFG_W    = 31;
    localparam int NORM_W   = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Iterative unit depths: one root bit or one quotient bit per stage
    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 32;

    // Register reset values (1.0 in Q16.16)
    localparam logic [CFG_W-1:0] RADIUS_RST      = 31'd65536;
    localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 31'd65536;
    localparam logic [CFG_W-1:0] INV_RADIUS_RST  = 31'd65536;

    // Register index, taken from paddr word bits
    typedef enum logic [1:0] {
        REG_RADIUS      = 2'd0,
        REG_HALF_HEIGHT = 2'd1,
        REG_INV_RADIUS  = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_NO_ROOT = 2'd1,
        ST_BEHIND  = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] dz;
    } t_ray;

    typedef struct packed {
        t_status                   status;
        logic                      shadow_hit;
        logic                      near_in;
        logic signed [COORD_W-1:0] near_t;
        logic signed [NORM_W-1:0]  near_nx;
        logic signed [NORM_W-1:0]  near_nz;
        logic                      far_in;
        logic signed [COORD_W-1:0] far_t;
        logic signed [NORM_W-1:0]  far_nx;
        logic signed [NORM_W-1:0]  far_nz;
    } t_hit;

    // Square root pipeline word: remainder and partial root
    typedef struct packed {
        t_ray               ray;
        logic signed [64:0] h;
        logic [63:0]        a;
        logic               noroot;
        logic [126:0]       rem;
        logic [63:0]        res;
    } t_sq;

    // Divider pipeline word, two roots side by side
    typedef struct packed {
        t_ray             ray;
        logic             noroot;
        logic [63:0]      a;
        logic [1:0]       neg;
        logic [1:0]       ovf;
        logic [1:0][80:0] rem;
        logic [1:0][31:0] q;
    } t_dv;

    // Scale a clamped magnitude product to Q1.14: floor, then saturate
    function automatic logic signed [NORM_W-1:0] norm_q14(input logic neg,
                                                         input logic [63:0] prod);
        logic [63:0] up;
        logic [45:0] q;
        up = prod + 64'd262143;
        if (!neg) begin
            q = prod[63:18];
            norm_q14 = (q > 46'd32767) ? 16'sd32767 : $signed(q[15:0]);
        end else begin
            q = up[63:18];
            norm_q14 = (q > 46'd32768) ? 16'h8000 : $signed(16'd0 - q[15:0]);
        end
    endfunction

endpackage

`default_nettype wire

// File: design/roc_ray_if.sv
// Ray input channel: valid/ready handshake with origin and direction beat.
// Depends on roc_pkg for field widths.
`default_nettype none

interface roc_ray_if;
    logic                                valid;
    logic                                ready;
    logic signed [roc_pkg::COORD_W-1:0]  origin_x;
    logic signed [roc_pkg::COORD_W-1:0]  origin_y;
    logic signed [roc_pkg::COORD_W-1:0]  origin_z;
    logic signed [roc_pkg::COORD_W-1:0]  dir_x;
    logic signed [roc_pkg::COORD_W-1:0]  dir_y;
    logic signed [roc_pkg::COORD_W-1:0]  dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

`default_nettype wire

// File: design/roc_hit_if.sv
// Hit result channel: valid/ready handshake with one intersection beat.
// Depends on roc_pkg for field widths and the status type.
`default_nettype none

interface roc_hit_if;
    logic                                valid;
    logic                                ready;
    roc_pkg::t_status                    status;
    logic                                shadow_hit;
    logic                                near_in;
    logic signed [roc_pkg::COORD_W-1:0]  near_t;
    logic signed [roc_pkg::NORM_W-1:0]   near_nx;
    logic signed [roc_pkg::NORM_W-1:0]   near_nz;
    logic                                far_in;
    logic signed [roc_pkg::COORD_W-1:0]  far_t;
    logic signed [roc_pkg::NORM_W-1:0]   far_nx;
    logic signed [roc_pkg::NORM_W-1:0]   far_nz;

    modport source (output valid, status, shadow_hit, near_in, near_t, near_nx, near_nz,
                    far_in, far_t, far_nx, far_nz, input ready);
    modport sink   (input valid, status, shadow_hit, near_in, near_t, near_nx, near_nz,
                    far_in, far_t, far_nx, far_nz, output ready);
endinterface

`default_nettype wire

// File: design/ray_open_cylinder_intersect.sv
// Ray against open y-axis cylinder, pipelined; uses roc_pkg, roc_ray_if, roc_hit_if.
// Throughput one ray per cycle while the result beat is not stalled.
// Depth is set by the square root (64 stages, one root bit each) and the
// dividers (32 stages, one quotient bit each). The whole pipe holds while the
// output register waits for ready. Sync active-low reset clears valid bits and
// loads radius, half height and inverse radius with 1.0.
`default_nettype none

module ray_open_cylinder_intersect (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    roc_ray_if.sink                            i_ray,
    roc_hit_if.source                          o_hit,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [roc_pkg::APB_AW-1:0]    paddr,
    input  wire logic [roc_pkg::APB_DW-1:0]    pwdata,
    output logic      [roc_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    localparam int NS = roc_pkg::SQRT_STEPS;
    localparam int ND = roc_pkg::DIV_STEPS;

    logic en;

    // Configuration registers
    logic [roc_pkg::CFG_W-1:0] r_radius;
    logic [roc_pkg::CFG_W-1:0] r_half_height;
    logic [roc_pkg::CFG_W-1:0] r_inv_radius;

    // Stage 1: squares and cross products
    logic                 r_s1_v;
    roc_pkg::t_ray        r_s1_ray;
    logic signed [63:0]   r_s1_pxd, r_s1_pzd;
    logic [62:0]          r_s1_dxx, r_s1_dzz, r_s1_oxx, r_s1_ozz;
    logic [61:0]          r_s1_rr;
    logic signed [63:0]   n_s1_dxx, n_s1_dzz, n_s1_oxx, n_s1_ozz;
    logic [61:0]          n_s1_rr;

    // Stage 2: a, u, h
    logic                 r_s2_v;
    roc_pkg::t_ray        r_s2_ray;
    logic [63:0]          r_s2_a, r_s2_u;
    logic signed [64:0]   r_s2_h;
    logic [61:0]          r_s2_rr;

    // Stage 3: |h| and |u - r^2|
    logic                 r_s3_v;
    roc_pkg::t_ray        r_s3_ray;
    logic [63:0]          r_s3_a;
    logic signed [64:0]   r_s3_h;
    logic [63:0]          r_s3_hm;
    logic                 r_s3_uge;
    logic [63:0]          r_s3_diff;
    logic [64:0]          n_s3_hneg, n_s3_ud;
    logic [63:0]          n_s3_du;

    // Stage 4: 32x32 partial products
    logic                 r_s4_v;
    roc_pkg::t_ray        r_s4_ray;
    logic [63:0]          r_s4_a;
    logic signed [64:0]   r_s4_h;
    logic                 r_s4_uge;
    logic [63:0]          r_s4_hll, r_s4_hlh, r_s4_hhh;
    logic [63:0]          r_s4_aldl, r_s4_aldh, r_s4_ahdl, r_s4_ahdh;
    logic [63:0]          n_s4_hll, n_s4_hlh, n_s4_hhh;
    logic [63:0]          n_s4_aldl, n_s4_aldh, n_s4_ahdl, n_s4_ahdh;

    // Stage 5: h^2 and middle sum of a*diff
    logic                 r_s5_v;
    roc_pkg::t_ray        r_s5_ray;
    logic [63:0]          r_s5_a;
    logic signed [64:0]   r_s5_h;
    logic                 r_s5_uge;
    logic [126:0]         r_s5_hsq;
    logic [64:0]          r_s5_mid;
    logic [63:0]          r_s5_aldl, r_s5_ahdh;
    logic [127:0]         n_s5_hsq;

    // Stage 6: a*diff
    logic                 r_s6_v;
    roc_pkg::t_ray        r_s6_ray;
    logic [63:0]          r_s6_a;
    logic signed [64:0]   r_s6_h;
    logic                 r_s6_uge;
    logic [126:0]         r_s6_hsq, r_s6_ac;
    logic [127:0]         n_s6_ac;

    // Stage 7 and square root pipe
    roc_pkg::t_sq         r_sq [0:NS];
    logic [NS:0]          r_sqv;
    logic [127:0]         n_s7_sub, n_s7_add;

    // Numerator stages
    logic                      r_n_v;
    roc_pkg::t_ray             r_n_ray;
    logic                      r_n_noroot;
    logic [63:0]               r_n_a;
    logic signed [65:0]        r_n_p0, r_n_p1;
    logic                      r_m_v;
    roc_pkg::t_ray             r_m_ray;
    logic                      r_m_noroot;
    logic [63:0]               r_m_a;
    logic [1:0]                r_m_neg;
    logic [1:0][64:0]          r_m_mag;
    logic [65:0]               n_m_neg0, n_m_neg1;

    // Divider pipe
    roc_pkg::t_dv              r_dv [0:ND];
    logic [ND:0]               r_dvv;
    roc_pkg::t_dv              n_dv0;

    // Saturated t
    logic                      r_t_v;
    roc_pkg::t_ray             r_t_ray;
    logic                      r_t_noroot;
    logic signed [1:0][31:0]   r_t_t;
    logic [1:0][31:0]          n_t_t;

    // t * d products
    logic                      r_p_v;
    roc_pkg::t_ray             r_p_ray;
    logic                      r_p_noroot;
    logic signed [1:0][31:0]   r_p_t;
    logic signed [1:0][63:0]   r_p_mx, r_p_my, r_p_mz;

    // Hit points
    logic                      r_q_v;
    logic                      r_q_noroot;
    logic signed [1:0][31:0]   r_q_t;
    logic signed [1:0][48:0]   r_q_x, r_q_y, r_q_z;

    // Height test and clamped magnitudes
    logic                      r_r_v;
    logic                      r_r_noroot;
    logic signed [1:0][31:0]   r_r_t;
    logic [1:0]                r_r_in;
    logic [1:0]                r_r_negx, r_r_negz;
    logic [1:0][33:0]          r_r_magx, r_r_magz;
    logic signed [48:0]        n_r_hh;
    logic [1:0][48:0]          n_r_absx, n_r_absz;

    // Normal products
    logic                      r_x_v;
    logic                      r_x_noroot;
    logic signed [1:0][31:0]   r_x_t;
    logic [1:0]                r_x_in;
    logic [1:0]                r_x_negx, r_x_negz;
    logic [1:0][63:0]          r_x_px, r_x_pz;

    // Output register
    logic                      r_ov;
    roc_pkg::t_hit             r_o;
    roc_pkg::t_hit             n_o;

    // Hold every stage while the output beat waits
    assign en          = !r_ov || o_hit.ready;
    assign i_ray.ready = en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= roc_pkg::RADIUS_RST;
            r_half_height <= roc_pkg::HALF_HEIGHT_RST;
            r_inv_radius  <= roc_pkg::INV_RADIUS_RST;
        end else if (psel && penable && pwrite) begin
            case (roc_pkg::t_reg'(paddr[3:2]))
                roc_pkg::REG_RADIUS:      r_radius      <= pwdata[roc_pkg::CFG_W-1:0];
                roc_pkg::REG_HALF_HEIGHT: r_half_height <= pwdata[roc_pkg::CFG_W-1:0];
                roc_pkg::REG_INV_RADIUS:  r_inv_radius  <= pwdata[roc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (roc_pkg::t_reg'(paddr[3:2]))
            roc_pkg::REG_RADIUS:      prdata = {1'b0, r_radius};
            roc_pkg::REG_HALF_HEIGHT: prdata = {1'b0, r_half_height};
            roc_pkg::REG_INV_RADIUS:  prdata = {1'b0, r_inv_radius};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0;
            r_s4_v <= 1'b0; r_s5_v <= 1'b0; r_s6_v <= 1'b0;
            r_sqv  <= '0;   r_n_v  <= 1'b0; r_m_v  <= 1'b0;
            r_dvv  <= '0;   r_t_v  <= 1'b0; r_p_v  <= 1'b0;
            r_q_v  <= 1'b0; r_r_v  <= 1'b0; r_x_v  <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_ray.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_sqv  <= {r_sqv[NS-1:0], r_s6_v};
            r_n_v  <= r_sqv[NS];
            r_m_v  <= r_n_v;
            r_dvv  <= {r_dvv[ND-1:0], r_m_v};
            r_t_v  <= r_dvv[ND];
            r_p_v  <= r_t_v;
            r_q_v  <= r_p_v;
            r_r_v  <= r_q_v;
            r_x_v  <= r_r_v;
            r_ov   <= r_x_v;
        end
    end

    // ---------------- stage 1: products ----------------
    always_comb begin
        n_s1_dxx = i_ray.dir_x * i_ray.dir_x;
        n_s1_dzz = i_ray.dir_z * i_ray.dir_z;
        n_s1_oxx = i_ray.origin_x * i_ray.origin_x;
        n_s1_ozz = i_ray.origin_z * i_ray.origin_z;
        n_s1_rr  = r_radius * r_radius;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ray <= '{ox: i_ray.origin_x, oy: i_ray.origin_y, oz: i_ray.origin_z,
                          dx: i_ray.dir_x, dy: i_ray.dir_y, dz: i_ray.dir_z};
            r_s1_pxd <= i_ray.origin_x * i_ray.dir_x;
            r_s1_pzd <= i_ray.origin_z * i_ray.dir_z;
            r_s1_dxx <= n_s1_dxx[62:0];
            r_s1_dzz <= n_s1_dzz[62:0];
            r_s1_oxx <= n_s1_oxx[62:0];
            r_s1_ozz <= n_s1_ozz[62:0];
            r_s1_rr  <= n_s1_rr;
        end
    end

    // ---------------- stage 2: sums ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ray <= r_s1_ray;
            r_s2_a   <= {1'b0, r_s1_dxx} + {1'b0, r_s1_dzz};
            r_s2_u   <= {1'b0, r_s1_oxx} + {1'b0, r_s1_ozz};
            r_s2_h   <= $signed({r_s1_pxd[63], r_s1_pxd} + {r_s1_pzd[63], r_s1_pzd});
            r_s2_rr  <= r_s1_rr;
        end
    end

    // ---------------- stage 3: magnitudes ----------------
    always_comb begin
        n_s3_hneg = 65'd0 - r_s2_h;
        n_s3_ud   = {1'b0, r_s2_u} - {3'b0, r_s2_rr};
        n_s3_du   = {2'b0, r_s2_rr} - r_s2_u;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ray  <= r_s2_ray;
            r_s3_a    <= r_s2_a;
            r_s3_h    <= r_s2_h;
            r_s3_hm   <= r_s2_h[64] ? n_s3_hneg[63:0] : r_s2_h[63:0];
            r_s3_uge  <= !n_s3_ud[64];
            r_s3_diff <= n_s3_ud[64] ? n_s3_du : n_s3_ud[63:0];
        end
    end

    // ---------------- stage 4: partial products ----------------
    always_comb begin
        n_s4_hll  = r_s3_hm[31:0]    * r_s3_hm[31:0];
        n_s4_hlh  = r_s3_hm[31:0]    * r_s3_hm[63:32];
        n_s4_hhh  = r_s3_hm[63:32]   * r_s3_hm[63:32];
        n_s4_aldl = r_s3_a[31:0]     * r_s3_diff[31:0];
        n_s4_aldh = r_s3_a[31:0]     * r_s3_diff[63:32];
        n_s4_ahdl = r_s3_a[63:32]    * r_s3_diff[31:0];
        n_s4_ahdh = r_s3_a[63:32]    * r_s3_diff[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_ray  <= r_s3_ray;
            r_s4_a    <= r_s3_a;
            r_s4_h    <= r_s3_h;
            r_s4_uge  <= r_s3_uge;
            r_s4_hll  <= n_s4_hll;
            r_s4_hlh  <= n_s4_hlh;
            r_s4_hhh  <= n_s4_hhh;
            r_s4_aldl <= n_s4_aldl;
            r_s4_aldh <= n_s4_aldh;
            r_s4_ahdl <= n_s4_ahdl;
            r_s4_ahdh <= n_s4_ahdh;
        end
    end

    // ---------------- stage 5: h^2 ----------------
    assign n_s5_hsq = {r_s4_hhh, r_s4_hll} + {31'b0, r_s4_hlh, 33'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_ray  <= r_s4_ray;
            r_s5_a    <= r_s4_a;
            r_s5_h    <= r_s4_h;
            r_s5_uge  <= r_s4_uge;
            r_s5_hsq  <= n_s5_hsq[126:0];
            r_s5_mid  <= {1'b0, r_s4_aldh} + {1'b0, r_s4_ahdl};
            r_s5_aldl <= r_s4_aldl;
            r_s5_ahdh <= r_s4_ahdh;
        end
    end

    // ---------------- stage 6: a * |u - r^2| ----------------
    assign n_s6_ac = {r_s5_ahdh, r_s5_aldl} + {31'b0, r_s5_mid, 32'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_ray <= r_s5_ray;
            r_s6_a   <= r_s5_a;
            r_s6_h   <= r_s5_h;
            r_s6_uge <= r_s5_uge;
            r_s6_hsq <= r_s5_hsq;
            r_s6_ac  <= n_s6_ac[126:0];
        end
    end

    // ---------------- stage 7: discriminant, root check ----------------
    assign n_s7_sub = {1'b0, r_s6_hsq} - {1'b0, r_s6_ac};
    assign n_s7_add = {1'b0, r_s6_hsq} + {1'b0, r_s6_ac};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0].ray    <= r_s6_ray;
            r_sq[0].h      <= r_s6_h;
            r_sq[0].a      <= r_s6_a;
            r_sq[0].noroot <= (r_s6_a == 64'd0) || (r_s6_uge && n_s7_sub[127]);
            r_sq[0].rem    <= r_s6_uge ? n_s7_sub[126:0] : n_s7_add[126:0];
            r_sq[0].res    <= '0;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    for (genvar gk = 0; gk < NS; gk++) begin : g_sqrt
        localparam int Bit = NS - 1 - gk;
        logic [127:0] trial;
        roc_pkg::t_sq n_sq;

        always_comb begin
            trial = ({64'b0, r_sq[gk].res} << (Bit + 1)) | (128'd1 << (2 * Bit));
            n_sq  = r_sq[gk];
            if ({1'b0, r_sq[gk].rem} >= trial) begin
                n_sq.rem = r_sq[gk].rem - trial[126:0];
                n_sq.res = r_sq[gk].res | (64'd1 << Bit);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[gk + 1] <= n_sq;
            end
        end
    end

    // ---------------- numerators: h + s and s - h ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_ray    <= r_sq[NS].ray;
            r_n_noroot <= r_sq[NS].noroot;
            r_n_a      <= r_sq[NS].a;
            r_n_p0     <= $signed({r_sq[NS].h[64], r_sq[NS].h} + {2'b0, r_sq[NS].res});
            r_n_p1     <= $signed({2'b0, r_sq[NS].res} - {r_sq[NS].h[64], r_sq[NS].h});
        end
    end

    // Near numerator is -(h + s), far is s - h: take sign and magnitude
    assign n_m_neg0 = 66'd0 - r_n_p0;
    assign n_m_neg1 = 66'd0 - r_n_p1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_ray    <= r_n_ray;
            r_m_noroot <= r_n_noroot;
            r_m_a      <= r_n_a;
            r_m_neg[0] <= !r_n_p0[65] && (r_n_p0 != 66'sd0);
            r_m_neg[1] <= r_n_p1[65];
            r_m_mag[0] <= r_n_p0[65] ? n_m_neg0[64:0] : r_n_p0[64:0];
            r_m_mag[1] <= r_n_p1[65] ? n_m_neg1[64:0] : r_n_p1[64:0];
        end
    end

    // ---------------- divider entry: scale and overflow check ----------------
    always_comb begin
        n_dv0.ray    = r_m_ray;
        n_dv0.noroot = r_m_noroot;
        n_dv0.a      = r_m_a;
        n_dv0.neg    = r_m_neg;
        n_dv0.q      = '0;
        for (int k = 0; k < 2; k++) begin
            n_dv0.rem[k] = {r_m_mag[k], 16'b0};
            n_dv0.ovf[k] = {15'b0, r_m_mag[k], 16'b0} >= {r_m_a, 32'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar gk = 0; gk < ND; gk++) begin : g_div
        localparam int Bit = ND - 1 - gk;
        logic [95:0] dvs;
        roc_pkg::t_dv n_dv;

        always_comb begin
            dvs  = {32'b0, r_dv[gk].a} << Bit;
            n_dv = r_dv[gk];
            for (int k = 0; k < 2; k++) begin
                if ({15'b0, r_dv[gk].rem[k]} >= dvs) begin
                    n_dv.rem[k]      = r_dv[gk].rem[k] - dvs[80:0];
                    n_dv.q[k][Bit]   = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[gk + 1] <= n_dv;
            end
        end
    end

    // ---------------- saturate and sign t ----------------
    always_comb begin
        logic [32:0] lim;
        logic [32:0] mag;
        for (int k = 0; k < 2; k++) begin
            lim = r_dv[ND].neg[k] ? 33'h080000000 : 33'h07FFFFFFF;
            mag = (r_dv[ND].ovf[k] || ({1'b0, r_dv[ND].q[k]} > lim))
                  ? lim : {1'b0, r_dv[ND].q[k]};
            mag = r_dv[ND].neg[k] ? (33'd0 - mag) : mag;
            n_t_t[k] = mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_ray    <= r_dv[ND].ray;
            r_t_noroot <= r_dv[ND].noroot;
            r_t_t      <= n_t_t;
        end
    end

    // ---------------- t * d ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ray    <= r_t_ray;
            r_p_noroot <= r_t_noroot;
            r_p_t      <= r_t_t;
            for (int k = 0; k < 2; k++) begin
                r_p_mx[k] <= $signed(r_t_t[k]) * r_t_ray.dx;
                r_p_my[k] <= $signed(r_t_t[k]) * r_t_ray.dy;
                r_p_mz[k] <= $signed(r_t_t[k]) * r_t_ray.dz;
            end
        end
    end

    // ---------------- hit points: o + floor(t*d / 2^16) ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_noroot <= r_p_noroot;
            r_q_t      <= r_p_t;
            for (int k = 0; k < 2; k++) begin
                r_q_x[k] <= 49'(r_p_ray.ox) + 49'($signed(r_p_mx[k]) >>> 16);
                r_q_y[k] <= 49'(r_p_ray.oy) + 49'($signed(r_p_my[k]) >>> 16);
                r_q_z[k] <= 49'(r_p_ray.oz) + 49'($signed(r_p_mz[k]) >>> 16);
            end
        end
    end

    // ---------------- height test, clamp magnitudes ----------------
    assign n_r_hh = $signed({18'b0, r_half_height});

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_r_absx[k] = r_q_x[k][48] ? (49'd0 - r_q_x[k]) : r_q_x[k];
            n_r_absz[k] = r_q_z[k][48] ? (49'd0 - r_q_z[k]) : r_q_z[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_noroot <= r_q_noroot;
            r_r_t      <= r_q_t;
            for (int k = 0; k < 2; k++) begin
                r_r_in[k]   <= ($signed(r_q_y[k]) >= -n_r_hh) &&
                               ($signed(r_q_y[k]) <= n_r_hh);
                r_r_negx[k] <= r_q_x[k][48];
                r_r_negz[k] <= r_q_z[k][48];
                r_r_magx[k] <= (n_r_absx[k] > 49'h2_0000_0000) ? 34'h2_0000_0000
                                                               : n_r_absx[k][33:0];
                r_r_magz[k] <= (n_r_absz[k] > 49'h2_0000_0000) ? 34'h2_0000_0000
                                                               : n_r_absz[k][33:0];
            end
        end
    end

    // ---------------- magnitude times inverse radius ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_noroot <= r_r_noroot;
            r_x_t      <= r_r_t;
            r_x_in     <= r_r_in;
            r_x_negx   <= r_r_negx;
            r_x_negz   <= r_r_negz;
            for (int k = 0; k < 2; k++) begin
                r_x_px[k] <= {30'b0, r_r_magx[k]} * {33'b0, r_inv_radius};
                r_x_pz[k] <= {30'b0, r_r_magz[k]} * {33'b0, r_inv_radius};
            end
        end
    end

    // ---------------- normals, status, shadow ----------------
    always_comb begin
        logic behind;
        behind = ($signed(r_x_t[0]) <= 32'sd0) && ($signed(r_x_t[1]) <= 32'sd0);
        n_o = '0;
        if (r_x_noroot) begin
            n_o.status = roc_pkg::ST_NO_ROOT;
        end else begin
            if (behind) begin
                n_o.status = roc_pkg::ST_BEHIND;
            end else if (!r_x_in[0] && !r_x_in[1]) begin
                n_o.status = roc_pkg::ST_OUTSIDE;
            end else begin
                n_o.status = roc_pkg::ST_HIT;
            end
            n_o.shadow_hit = (($signed(r_x_t[0]) > 32'sd0) && r_x_in[0]) ||
                             (($signed(r_x_t[1]) > 32'sd0) && r_x_in[1]);
            n_o.near_in = r_x_in[0];
            n_o.near_t  = r_x_t[0];
            n_o.far_in  = r_x_in[1];
            n_o.far_t   = r_x_t[1];
            if (r_x_in[0]) begin
                n_o.near_nx = roc_pkg::norm_q14(r_x_negx[0], r_x_px[0]);
                n_o.near_nz = roc_pkg::norm_q14(r_x_negz[0], r_x_pz[0]);
            end
            if (r_x_in[1]) begin
                n_o.far_nx = roc_pkg::norm_q14(r_x_negx[1], r_x_px[1]);
                n_o.far_nz = roc_pkg::norm_q14(r_x_negz[1], r_x_pz[1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o <= n_o;
        end
    end

    // Drive the result beat
    assign o_hit.valid      = r_ov;
    assign o_hit.status     = r_o.status;
    assign o_hit.shadow_hit = r_o.shadow_hit;
    assign o_hit.near_in    = r_o.near_in;
    assign o_hit.near_t     = r_o.near_t;
    assign o_hit.near_nx    = r_o.near_nx;
    assign o_hit.near_nz    = r_o.near_nz;
    assign o_hit.far_in     = r_o.far_in;
    assign o_hit.far_t      = r_o.far_t;
    assign o_hit.far_nx     = r_o.far_nx;
    assign o_hit.far_nz     = r_o.far_nz;

endmodule

`default_nettype wire
